@@ hdl/jvr_pkg.sv @@
// Shared types, constants and register codes for the jog velocity ramp.
// No dependencies; used by every module of the block.
package jvr_pkg;

  localparam int SpeedW  = 32;
  localparam int VelW    = 31;
  localparam int PeriodW = 24;
  localparam int CfgIdxW = 3;
  localparam int ProdW   = SpeedW + PeriodW;

  // Comparison margin in Q16.16 LSBs (range 0 to 65536).
  localparam logic [SpeedW+1:0] TOLERANCE = 34'd1;

  // Defaults loaded at reset; velocity and acceleration also load theirs when zero is written.
  localparam logic [VelW-1:0]    DEF_VEL    = 31'd66;
  localparam logic [VelW-1:0]    DEF_ACC    = 31'd655;
  localparam logic [PeriodW-1:0] DEF_PERIOD = 24'd16777;

  // Half an LSB of the Q0.24 product, for round to nearest.
  localparam logic [ProdW-1:0] ROUND_HALF = 56'h0000_0000_80_0000;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_JOG_VELOCITY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_JOG_ACCEL    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TICK_PERIOD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IDLE_LOWER   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IDLE_UPPER   = 3'd4;

  typedef struct packed {
    logic        [VelW-1:0]    jog_velocity;
    logic        [VelW-1:0]    jog_accel;
    logic        [PeriodW-1:0] tick_period;
    logic signed [SpeedW-1:0]  idle_lower;
    logic signed [SpeedW-1:0]  idle_upper;
  } jvr_cfg_t;

endpackage

@@ hdl/jvr_regs.sv @@
// Configuration register file for the jog velocity ramp.
// Depends on jvr_pkg; zero writes to velocity or acceleration load defaults.
module jvr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [jvr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [jvr_pkg::SpeedW-1:0]    cfg_wdata,
  output jvr_pkg::jvr_cfg_t             cfg_o
);
  import jvr_pkg::*;

  jvr_cfg_t cfg_r;
  jvr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_JOG_VELOCITY: begin
          cfg_nxt.jog_velocity = (cfg_wdata[VelW-1:0] == '0) ? DEF_VEL : cfg_wdata[VelW-1:0];
        end
        REG_JOG_ACCEL: begin
          cfg_nxt.jog_accel = (cfg_wdata[VelW-1:0] == '0) ? DEF_ACC : cfg_wdata[VelW-1:0];
        end
        REG_TICK_PERIOD: cfg_nxt.tick_period = cfg_wdata[PeriodW-1:0];
        REG_IDLE_LOWER:  cfg_nxt.idle_lower  = cfg_wdata;
        REG_IDLE_UPPER:  cfg_nxt.idle_upper  = cfg_wdata;
        default: ;  // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jog_velocity <= DEF_VEL;
      cfg_r.jog_accel    <= DEF_ACC;
      cfg_r.tick_period  <= DEF_PERIOD;
      cfg_r.idle_lower   <= '0;
      cfg_r.idle_upper   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ hdl/jvr_scaler.sv @@
// Shared period scaler: registered round(mag * tick_period / 2^24).
// Depends on jvr_pkg for widths and the rounding constant.
module jvr_scaler (
  input  logic                          clk,
  input  logic                          en,
  input  logic [jvr_pkg::SpeedW-1:0]    mag,
  input  logic [jvr_pkg::PeriodW-1:0]   period,
  output logic [jvr_pkg::SpeedW-1:0]    result_r
);
  import jvr_pkg::*;

  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  rounded;
  logic [SpeedW-1:0] result_nxt;

  // mag is at most 2^31, so the scaled value always stays below 2^31 + 1.
  assign prod       = ProdW'(mag) * ProdW'(period);
  assign rounded    = prod + ROUND_HALF;
  assign result_nxt = rounded[ProdW-1:PeriodW];

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

endmodule

@@ hdl/jog_velocity_ramp.sv @@
// Jog velocity ramp: trapezoidal jog speed profile in Q16.16 fixed point.
// A tick item passes the step scale, the speed update, the displacement scale
// and the sign restore, with both scales on the one shared period multiplier;
// a stop in the idle band or a held stop skips the last two; a sync item goes
// straight to output. Input stalls until the result enters the output register.
// Reset (rst_n, synchronous): speed and displacement zero, registers defaults.
module jog_velocity_ramp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [jvr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [jvr_pkg::SpeedW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic signed [1:0]             in_direction,
  input  logic signed [31:0]            in_sync_speed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_current_speed,
  output logic signed [31:0]            out_period_displacement
);
  import jvr_pkg::*;

  localparam int WideW = SpeedW + 2;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for an input transfer
  localparam logic [2:0] S_STEP = 3'd1;  // scaler forms accel * period
  localparam logic [2:0] S_UPD  = 3'd2;  // ramp the speed by the step
  localparam logic [2:0] S_DISP = 3'd3;  // scaler forms |speed| * period
  localparam logic [2:0] S_FIN  = 3'd4;  // restore the displacement sign
  localparam logic [2:0] S_DONE = 3'd5;  // hand the result to the output register

  jvr_cfg_t cfg;

  logic [2:0]               state_r, state_nxt;
  logic [1:0]               dir_r;
  logic signed [SpeedW-1:0] speed_r, speed_nxt;
  logic signed [SpeedW-1:0] disp_r, disp_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [SpeedW-1:0] out_speed_r, out_disp_r;

  logic                     scl_en;
  logic [SpeedW-1:0]        scl_mag;
  logic [SpeedW-1:0]        scl_res;
  logic [SpeedW-1:0]        speed_abs;

  logic                     in_xfer;
  logic                     out_free;

  // Ramp datapath, all at 34 bits so no compare can wrap.
  logic signed [WideW-1:0]  s_w, step_w, vel_w, vt_w, tol_w, t_w, a_w, lo_w, up_w;
  logic                     upd_disp;
  logic [2:0]               upd_next;

  function automatic logic signed [SpeedW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi, lo;
    hi = WideW'({1'b0, {(SpeedW-1){1'b1}}});
    lo = -hi - WideW'(1);
    if (v > hi) return hi[SpeedW-1:0];
    else if (v < lo) return lo[SpeedW-1:0];
    else return v[SpeedW-1:0];
  endfunction

  function automatic logic signed [WideW-1:0] abs34(input logic signed [WideW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  jvr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // One multiplier serves both the step and the displacement.
  assign speed_abs = speed_r[SpeedW-1] ? (~speed_r + SpeedW'(1)) : speed_r;
  assign scl_en    = (state_r == S_STEP) || (state_r == S_DISP);
  assign scl_mag   = (state_r == S_STEP) ? {1'b0, cfg.jog_accel} : speed_abs;

  jvr_scaler u_scaler (
    .clk      (clk),
    .en       (scl_en),
    .mag      (scl_mag),
    .period   (cfg.tick_period),
    .result_r (scl_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Speed update for a tick: forward, reverse or stop.
  always_comb begin
    s_w      = WideW'(speed_r);
    step_w   = WideW'({1'b0, scl_res});
    vel_w    = WideW'({1'b0, cfg.jog_velocity});
    tol_w    = TOLERANCE;
    vt_w     = vel_w + tol_w;
    lo_w     = WideW'(cfg.idle_lower);
    up_w     = WideW'(cfg.idle_upper);
    t_w      = s_w;
    a_w      = abs34(s_w);
    upd_disp = 1'b0;
    upd_next = S_DONE;
    speed_nxt = speed_r;
    disp_nxt  = disp_r;
    if (dir_r == 2'b00) begin
      if ((s_w - lo_w > -tol_w) && (s_w - up_w < tol_w)) begin
        // Stop inside the idle band: snap everything to zero.
        speed_nxt = '0;
        disp_nxt  = '0;
      end else if (s_w >= tol_w) begin
        t_w = s_w - step_w;
        if (t_w <= tol_w) t_w = '0;
        speed_nxt = sat32(t_w);
        upd_disp  = 1'b1;
      end else if (s_w <= -tol_w) begin
        t_w = s_w + step_w;
        if (t_w >= tol_w) t_w = '0;
        speed_nxt = sat32(t_w);
        upd_disp  = 1'b1;
      end
    end else if (dir_r[1]) begin
      // Reverse: the limit is checked on the magnitude, so a large forward
      // speed holds as well.
      if (a_w < vt_w) begin
        t_w = s_w - step_w;
        if (abs34(t_w) >= vt_w) t_w = -vel_w;
        speed_nxt = sat32(t_w);
      end
      upd_disp = 1'b1;
    end else begin
      if (s_w < vt_w) begin
        t_w = s_w + step_w;
        if (t_w >= vt_w) t_w = vel_w;
        speed_nxt = sat32(t_w);
      end
      upd_disp = 1'b1;
    end
    if (upd_disp) upd_next = S_DISP;
  end

  // Sequencer and state registers.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = in_cmd ? S_DONE : S_STEP;
      end
      S_STEP: state_nxt = S_UPD;
      S_UPD:  state_nxt = upd_next;
      S_DISP: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      speed_r     <= '0;
      disp_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer && in_cmd) begin
        // Sync: load the speed, keep the displacement.
        speed_r <= in_sync_speed;
      end else if (state_r == S_UPD) begin
        speed_r <= speed_nxt;
        disp_r  <= disp_nxt;
      end else if (state_r == S_FIN) begin
        // The scaled magnitude is at most 2^31, so negating it always fits.
        disp_r <= speed_r[SpeedW-1] ? (~scl_res + SpeedW'(1)) : scl_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dir_r <= in_direction;
    end
    if (state_r == S_DONE && out_free) begin
      out_speed_r <= speed_r;
      out_disp_r  <= disp_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_current_speed       = out_speed_r;
  assign out_period_displacement = out_disp_r;

endmodule
